/* hw/rtl/lsws_pkg.sv */
// ----------------------------------------------------------------------------
// lsws_pkg: shared types and constants for the LIFO stack with search
// Request and result word layouts, request kinds and controller states.
// ----------------------------------------------------------------------------
package lsws_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DepthDef    = 16;
  localparam int unsigned WordBitsDef = 32;

  // Fixed field widths of the request and result words
  localparam int unsigned ValueBits   = 32;
  localparam int unsigned PosBits     = 4;
  localparam int unsigned EntriesBits = 5;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_READ   = 3'b010,
    ST_SEARCH = 3'b100
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [ValueBits-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [ValueBits-1:0]   data_out;
    logic [PosBits-1:0]     position;
    logic                   found;
    logic                   was_empty;
    logic                   overflow;
    logic [EntriesBits-1:0] entries;
  } out_word_t;

endpackage

/* hw/rtl/lifo_stack_with_search_core.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_search_core: bounded LIFO stack with search
// Push, pop, peek and search-from-top over a DEPTH-entry word store.
// ----------------------------------------------------------------------------
// Each request word gives exactly one result word, carrying the entry count
// after the request. The entry memory has a single read port with registered
// read data. A push, or a pop/peek/search on an empty stack, is answered from
// idle; a pop or peek reads the top entry and answers from ST_READ; a search
// reads down from the top in ST_SEARCH until a hit or the last entry held.
// One request is in work at a time; the next is taken once the block is idle
// and the output register is empty or hands its word off in that same cycle,
// so a result held by out_stall_i also holds off the next request.
// A push to a full stack is dropped and flagged as overflow. Entry contents
// are not cleared at reset; only entries below the fill count are ever read.
module lifo_stack_with_search_core #(
  parameter int unsigned DEPTH     = lsws_pkg::DepthDef,
  parameter int unsigned WORD_BITS = lsws_pkg::WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lsws_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsws_pkg::out_word_t out_word_o
);
  import lsws_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);      // memory address bits
  localparam int unsigned CW = $clog2(DEPTH + 1);  // fill count bits

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;          // entries held
  logic [AW-1:0]   k_q, k_d;              // search: position now compared
  logic [WORD_BITS-1:0] key_q, key_d;     // search key

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  out_word_t out_q, res;
  logic      out_valid_q, load_out;
  logic      out_free, accept;
  logic [WORD_BITS-1:0] in_word;
  logic      hit, last;

  // Fields wider than WORD_BITS are truncated, narrower ones zero-extended
  assign in_word  = WORD_BITS'(64'(in_word_i.value));

  // Output register may take a new result if empty or draining this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Search compare on the word from the most recent read (position k_q)
  assign hit  = (mem_rdata == key_q);
  assign last = ((CW'(k_q) + CW'(1)) == cnt_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    key_d     = key_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(cnt_q);
    mem_wdata = in_word;
    mem_re    = 1'b0;
    mem_raddr = AW'(cnt_q - CW'(1));
    load_out  = 1'b0;
    res       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_word_i.kind)
            KIND_PUSH: begin
              load_out = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                res.overflow = 1'b1;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (cnt_q == '0) begin
                res.was_empty = 1'b1;
                load_out      = 1'b1;
              end else begin
                mem_re  = 1'b1;            // top entry
                state_d = ST_READ;
                if (in_word_i.kind == KIND_POP) begin
                  cnt_d = cnt_q - CW'(1);
                end
              end
            end
            KIND_SEARCH: begin
              key_d = in_word;
              if (cnt_q == '0) begin
                load_out = 1'b1;           // miss on empty stack
              end else begin
                mem_re  = 1'b1;            // start at the top
                k_d     = '0;
                state_d = ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        // Read data holds until the next read, so waiting here is safe
        if (out_free) begin
          res.data_out = ValueBits'(64'(mem_rdata));
          load_out     = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_SEARCH: begin
        if (hit || last) begin
          if (out_free) begin
            res.found    = hit;
            res.position = hit ? PosBits'(32'(k_q)) : '0;
            load_out     = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          // Next entry down: address cnt - 1 - (k + 1)
          mem_re    = 1'b1;
          mem_raddr = AW'(cnt_q - CW'(k_q) - CW'(2));
          k_d       = k_q + AW'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase

    res.entries = EntriesBits'(32'(cnt_d));
  end

  // Write happens only on a push from idle, reads only on pop/peek/search,
  // so the two ports never touch the same entry in one cycle.
  lsws_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    key_q <= key_d;
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* hw/rtl/lsws_mem.sv */
// ----------------------------------------------------------------------------
// lsws_mem: entry storage of the stack
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module lsws_mem #(
  parameter int unsigned DEPTH     = lsws_pkg::DepthDef,
  parameter int unsigned WORD_BITS = lsws_pkg::WordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  logic [WORD_BITS-1:0]         wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [WORD_BITS-1:0]         rdata_o
);
  import lsws_pkg::*;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lsws_checker.sv */
// ----------------------------------------------------------------------------
// lsws_checker: port-level checks for the LIFO stack with search
// Result word consistency and output hold under stall.
// ----------------------------------------------------------------------------
module lsws_checker #(
  parameter int unsigned DEPTH = lsws_pkg::DepthDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lsws_pkg::out_word_t out_word_o
);
  import lsws_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // At most one of found, was_empty, overflow per result
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_word_o.found, out_word_o.was_empty,
                                out_word_o.overflow}) <= 1)
    else $error("conflicting result flags");

  // Empty pop/peek returns zero data and an empty count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.was_empty |->
      out_word_o.data_out == '0 && out_word_o.entries == '0)
    else $error("empty result with data or entries");

  // A miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |-> out_word_o.position == '0)
    else $error("nonzero position without a hit");

  // Entry count never exceeds the depth (when the field can show it)
  a_entries_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH >= 32) || (32'(out_word_o.entries) <= DEPTH))
    else $error("entry count beyond depth");

endmodule

bind lifo_stack_with_search_core lsws_checker #(.DEPTH(DEPTH)) u_lsws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
